[hw/rtl/dtmfr_pkg.sv]
// Shared types, character codes and keyword tables for the DTMF relay body parser.
// No dependencies; imported by dtmfr_parse_core and dtmf_relay_body_parser.
package dtmfr_pkg;

	// Characters the parser reacts to
	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [7:0] CHAR_LF    = 8'h0A;
	localparam logic [7:0] CHAR_SP    = 8'h20;
	localparam logic [7:0] CHAR_0     = 8'h30;
	localparam logic [7:0] CHAR_9     = 8'h39;
	localparam logic [7:0] CHAR_UP_A  = 8'h41;
	localparam logic [7:0] CHAR_UP_Z  = 8'h5A;
	localparam logic [7:0] CASE_DELTA = 8'h20;

	// Keyword lengths, including the '='
	localparam int SIG_KW_LEN = 7;
	localparam int DUR_KW_LEN = 9;

	// Saturation limits
	localparam logic [2:0]  LEN_MAX = 3'd7;
	localparam logic [13:0] ACC_MAX = 14'd16383;

	// Result status codes
	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_FAIL = 1'b1;

	typedef enum logic [1:0] {
		PH_KEY,
		PH_LEAD,
		PH_VALUE,
		PH_SKIP
	} phase_t;

	typedef enum logic [1:0] {
		KIND_NONE,
		KIND_SIGNAL,
		KIND_DURATION
	} kind_t;

	// One parse result, handed from the core to the output register
	typedef struct packed {
		logic        valid;
		logic        status;
		logic [7:0]  signal_char;
		logic [13:0] duration_value;
	} dtmfr_res_t;

	// Lower-case "signal=" by column
	function automatic logic [7:0] sig_kw_char(input logic [3:0] col);
		logic [7:0] c;
		case (col)
			4'd0:    c = 8'h73; // s
			4'd1:    c = 8'h69; // i
			4'd2:    c = 8'h67; // g
			4'd3:    c = 8'h6E; // n
			4'd4:    c = 8'h61; // a
			4'd5:    c = 8'h6C; // l
			4'd6:    c = 8'h3D; // =
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// Lower-case "duration=" by column
	function automatic logic [7:0] dur_kw_char(input logic [3:0] col);
		logic [7:0] c;
		case (col)
			4'd0:    c = 8'h64; // d
			4'd1:    c = 8'h75; // u
			4'd2:    c = 8'h72; // r
			4'd3:    c = 8'h61; // a
			4'd4:    c = 8'h74; // t
			4'd5:    c = 8'h69; // i
			4'd6:    c = 8'h6F; // o
			4'd7:    c = 8'h6E; // n
			4'd8:    c = 8'h3D; // =
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CHAR_0) && (c <= CHAR_9);
	endfunction

endpackage

[hw/rtl/dtmfr_parse_core.sv]
// Per-byte parse state and its registered update for the DTMF relay body parser.
// Depends on dtmfr_pkg; instantiated by dtmf_relay_body_parser.
module dtmfr_parse_core
	import dtmfr_pkg::*;
#(
	parameter int DURATION_CHARS = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic [7:0] data_byte,
	input  logic       new_message,
	output dtmfr_res_t res
);

	// Parse state
	phase_t      line_phase_q, line_phase_n;
	logic [3:0]  column_q, column_n;
	logic        signal_match_q, signal_match_n;
	logic        duration_match_q, duration_match_n;
	kind_t       line_kind_q, line_kind_n;
	logic        prev_was_cr_q, prev_was_cr_n;
	logic [2:0]  trimmed_len_q, trimmed_len_n;
	logic [2:0]  raw_value_len_q, raw_value_len_n;
	logic [13:0] digit_acc_q, digit_acc_n;
	logic        digits_stopped_q, digits_stopped_n;
	logic [7:0]  first_value_char_q, first_value_char_n;
	logic [8:0]  signal_seen_q, signal_seen_n;
	logic [14:0] duration_seen_q, duration_seen_n;
	logic        finished_q, finished_n;

	logic res_valid;
	logic res_fail;

	// Next-state logic: one byte per enabled cycle
	always_comb begin
		logic [7:0]  folded;
		logic        take_val;
		logic        bad_dur;
		logic [17:0] acc_ext;

		folded   = 8'h00;
		take_val = 1'b0;
		bad_dur  = 1'b0;
		acc_ext  = 18'd0;

		line_phase_n       = line_phase_q;
		column_n           = column_q;
		signal_match_n     = signal_match_q;
		duration_match_n   = duration_match_q;
		line_kind_n        = line_kind_q;
		prev_was_cr_n      = prev_was_cr_q;
		trimmed_len_n      = trimmed_len_q;
		raw_value_len_n    = raw_value_len_q;
		digit_acc_n        = digit_acc_q;
		digits_stopped_n   = digits_stopped_q;
		first_value_char_n = first_value_char_q;
		signal_seen_n      = signal_seen_q;
		duration_seen_n    = duration_seen_q;
		finished_n         = finished_q;
		res_valid          = 1'b0;
		res_fail           = 1'b0;

		// New message wipes everything before the byte is looked at
		if (new_message) begin
			line_phase_n       = PH_KEY;
			column_n           = 4'd0;
			signal_match_n     = 1'b1;
			duration_match_n   = 1'b1;
			line_kind_n        = KIND_NONE;
			prev_was_cr_n      = 1'b0;
			trimmed_len_n      = 3'd0;
			raw_value_len_n    = 3'd0;
			digit_acc_n        = 14'd0;
			digits_stopped_n   = 1'b0;
			first_value_char_n = 8'h00;
			signal_seen_n      = 9'd0;
			duration_seen_n    = 15'd0;
			finished_n         = 1'b0;
		end

		if (!finished_n) begin
			if (data_byte == CHAR_LF && prev_was_cr_n) begin
				// LF of a CR LF pair is dropped
				prev_was_cr_n = 1'b0;
			end else if (data_byte != CHAR_CR) begin
				prev_was_cr_n = 1'b0;
				case (line_phase_n)
					PH_KEY: begin
						folded = (data_byte >= CHAR_UP_A && data_byte <= CHAR_UP_Z) ?
							data_byte + CASE_DELTA : data_byte;
						signal_match_n = signal_match_n && (column_n < 4'(SIG_KW_LEN))
							&& (folded == sig_kw_char(column_n));
						duration_match_n = duration_match_n && (column_n < 4'(DUR_KW_LEN))
							&& (folded == dur_kw_char(column_n));
						if (signal_match_n && column_n == 4'(SIG_KW_LEN - 1)) begin
							line_kind_n  = KIND_SIGNAL;
							line_phase_n = PH_LEAD;
						end else if (duration_match_n && column_n == 4'(DUR_KW_LEN - 1)) begin
							line_kind_n  = KIND_DURATION;
							line_phase_n = PH_LEAD;
						end else if (!signal_match_n && !duration_match_n) begin
							line_phase_n = PH_SKIP;
						end else begin
							column_n = column_n + 4'd1;
						end
					end
					PH_LEAD: begin
						if (data_byte != CHAR_SP) begin
							first_value_char_n = data_byte;
							line_phase_n       = PH_VALUE;
							take_val           = 1'b1;
						end
					end
					PH_VALUE: begin
						take_val = 1'b1;
					end
					default: begin
					end
				endcase

				// Value byte: lengths and leading digit run
				if (take_val) begin
					if (raw_value_len_n < LEN_MAX)
						raw_value_len_n = raw_value_len_n + 3'd1;
					if (data_byte != CHAR_SP)
						trimmed_len_n = raw_value_len_n;
					if (!digits_stopped_n) begin
						if (is_digit(data_byte)) begin
							acc_ext = ({4'd0, digit_acc_n} << 3) + ({4'd0, digit_acc_n} << 1)
								+ {14'd0, data_byte[3:0]};
							digit_acc_n = (acc_ext > {4'd0, ACC_MAX}) ? ACC_MAX : acc_ext[13:0];
						end else begin
							digits_stopped_n = 1'b1;
						end
					end
				end
			end else begin
				// CR closes the line
				prev_was_cr_n = 1'b1;
				if (line_kind_n == KIND_SIGNAL) begin
					signal_seen_n = {1'b1, first_value_char_n};
				end else if (line_kind_n == KIND_DURATION) begin
					bad_dur = (trimmed_len_n == 3'd0)
						|| (trimmed_len_n > 3'(DURATION_CHARS))
						|| !is_digit(first_value_char_n);
					if (!bad_dur)
						duration_seen_n = {1'b1, digit_acc_n};
				end
				line_phase_n       = PH_KEY;
				column_n           = 4'd0;
				signal_match_n     = 1'b1;
				duration_match_n   = 1'b1;
				line_kind_n        = KIND_NONE;
				trimmed_len_n      = 3'd0;
				raw_value_len_n    = 3'd0;
				digit_acc_n        = 14'd0;
				digits_stopped_n   = 1'b0;
				first_value_char_n = 8'h00;
				if (bad_dur) begin
					finished_n = 1'b1;
					res_valid  = 1'b1;
					res_fail   = 1'b1;
				end else if (signal_seen_n[8] && duration_seen_n[14]) begin
					finished_n = 1'b1;
					res_valid  = 1'b1;
				end
			end
		end
	end

	// Result fields
	always_comb begin
		res.valid          = res_valid;
		res.status         = res_fail ? STATUS_FAIL : STATUS_OK;
		res.signal_char    = res_fail ? 8'h00 : signal_seen_n[7:0];
		res.duration_value = res_fail ? 14'd0 : duration_seen_n[13:0];
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_phase_q       <= PH_KEY;
			column_q           <= 4'd0;
			signal_match_q     <= 1'b1;
			duration_match_q   <= 1'b1;
			line_kind_q        <= KIND_NONE;
			prev_was_cr_q      <= 1'b0;
			trimmed_len_q      <= 3'd0;
			raw_value_len_q    <= 3'd0;
			digit_acc_q        <= 14'd0;
			digits_stopped_q   <= 1'b0;
			first_value_char_q <= 8'h00;
			signal_seen_q      <= 9'd0;
			duration_seen_q    <= 15'd0;
			finished_q         <= 1'b0;
		end else if (en) begin
			line_phase_q       <= line_phase_n;
			column_q           <= column_n;
			signal_match_q     <= signal_match_n;
			duration_match_q   <= duration_match_n;
			line_kind_q        <= line_kind_n;
			prev_was_cr_q      <= prev_was_cr_n;
			trimmed_len_q      <= trimmed_len_n;
			raw_value_len_q    <= raw_value_len_n;
			digit_acc_q        <= digit_acc_n;
			digits_stopped_q   <= digits_stopped_n;
			first_value_char_q <= first_value_char_n;
			signal_seen_q      <= signal_seen_n;
			duration_seen_q    <= duration_seen_n;
			finished_q         <= finished_n;
		end
	end

	// Once finished, nothing comes out until a new message
	a_quiet_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		(finished_q && !new_message) |-> !res_valid)
		else $error("result produced after message finished");

	a_result_sets_finished: assert property (@(posedge clk) disable iff (!arst_n)
		(en && res_valid) |=> finished_q)
		else $error("finished flag not set after result");

	a_kind_implies_value_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(line_kind_q != KIND_NONE) |-> (line_phase_q == PH_LEAD || line_phase_q == PH_VALUE))
		else $error("line kind set outside value phases");

endmodule

[hw/rtl/dtmf_relay_body_parser.sv]
// Top level of the DTMF relay body parser: input register, parse core, result register.
// Depends on dtmfr_pkg and dtmfr_parse_core.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one body byte per transaction in
//   data_byte; new_message marks the first byte of a message and clears all parse
//   state before that byte is handled.
//   Output channel (out_valid / out_stall) carries at most one result per message:
//   status ok with signal_char and duration_value once both a Signal and a Duration
//   line have been closed by CR, or status failed (fields zero) on a malformed
//   Duration line. After a result, bytes are dropped until new_message.
//   An accepted byte waits in the input register and is parsed as it leaves it; a result
//   it causes is captured in the result register and then shows on the output ports.
//   Throughput: one byte per cycle while no stalled result holds the output register.
//   Reset (arst_n low) clears the parse state and both registers; no result pending.
//   When the receiver stalls with a result held, the byte waiting in the input
//   register is held too and in_stall rises; bytes keep flowing while the output
//   register is empty or being drained.
module dtmf_relay_body_parser
	import dtmfr_pkg::*;
#(
	parameter int DURATION_CHARS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        new_message,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        status,
	output logic [7:0]  signal_char,
	output logic [13:0] duration_value
);

	logic       valid_s1;
	logic [7:0] data_byte_s1;
	logic       new_message_s1;
	logic       advance;
	logic       in_accept;
	dtmfr_res_t core_res;
	dtmfr_res_t out_q;

	// Byte in stage 1 moves on when the result register can take whatever it yields
	assign advance   = valid_s1 && (!out_q.valid || !out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign in_accept = in_valid && !in_stall;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			data_byte_s1   <= data_byte;
			new_message_s1 <= new_message;
		end
	end

	dtmfr_parse_core #(
		.DURATION_CHARS(DURATION_CHARS)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (advance),
		.data_byte  (data_byte_s1),
		.new_message(new_message_s1),
		.res        (core_res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_q <= '0;
		end else if (advance && core_res.valid) begin
			out_q <= core_res;
		end else if (!out_stall) begin
			out_q.valid <= 1'b0;
		end
	end

	assign out_valid      = out_q.valid;
	assign status         = out_q.status;
	assign signal_char    = out_q.signal_char;
	assign duration_value = out_q.duration_value;

	// A held result must hold back the waiting byte
	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_q.valid && out_stall) |-> in_stall)
		else $error("input not held while result stalled");

	// A result from the core lands in the output register
	a_result_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && core_res.valid) |=> out_q.valid)
		else $error("core result lost");

	// Failed results carry zero fields
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_q.valid && out_q.status == STATUS_FAIL) |->
			(out_q.signal_char == 8'h00 && out_q.duration_value == 14'd0))
		else $error("failed result with nonzero fields");

endmodule
